### rtl/clbp_pkg.sv
// ----------------------------------------------------------------------------
// clbp_pkg
// Shared types and constants for the circular LBP spatial histogram block.
// ----------------------------------------------------------------------------
package clbp_pkg;

  // Diagonal interpolation weights, Q.16, summing to 65536
  localparam int unsigned WeightBits = 16;
  localparam logic [15:0] W_CORNER = 16'd32768;
  localparam logic [15:0] W_SIDE   = 16'd13573;
  localparam logic [15:0] W_CENTRE = 16'd5622;

  // Configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GRID_COLS    = 2'd2;
  localparam logic [1:0] REG_GRID_ROWS    = 2'd3;

  // Operand selection for the shared divider
  localparam logic [1:0] DIV_CELL_W = 2'd0;
  localparam logic [1:0] DIV_CELL_H = 2'd1;
  localparam logic [1:0] DIV_FRAC   = 2'd2;

  // Input item function codes
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned DivW     = 16;

  typedef struct packed {
    logic       take_in;
    logic       div_start;
    logic [1:0] div_sel;
    logic       ld_cw;
    logic       ld_ch;
    logic       init_frame;
    logic       clr_en;
    logic       pix_rd;
    logic       pix_exec;
    logic       hist_wr;
    logic       rd_issue;
    logic       rd_latch;
    logic       frac_ld;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic in_func;
    logic in_sof;
    logic div_done;
    logic clr_last;
    logic pix_ok;
    logic count_ok;
    logic need_div;
    logic out_free;
  } status_t;

endpackage

### rtl/circular_lbp_spatial_histogram.sv
// ----------------------------------------------------------------------------
// circular_lbp_spatial_histogram
// Radius-1, 8-neighbour circular LBP over a pixel stream with per-cell
// 256-bin histograms and a bin read-out.
// ----------------------------------------------------------------------------
// Pixel word: row check, line-store and window update, and a histogram increment
//   when counted; past the last row only the row check runs. Start of frame first
//   divides for cell width and height, then clears all MAX_GRID*MAX_GRID*256 bins.
// Read word: read, latch, fraction division if needed, output load once free.
// Reset is asynchronous, active low; a clearing pass over the same bins follows
//   reset with the input held not ready, so histograms read zero after it.
module circular_lbp_spatial_histogram #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_GRID   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel[7:0], start_of_frame[8], cell_index[14:9], bin_index[22:15]
  input  logic [23:0] s_axis_tdata,
  // func[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bin_count[15:0], bin_fraction[32:16]
  output logic [39:0] m_axis_tdata
);

  clbp_pkg::cmd_t    cmd;
  clbp_pkg::status_t status;

  clbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  clbp_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_GRID   (MAX_GRID)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tdata_o   (m_axis_tdata),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

### rtl/clbp_div.sv
// ----------------------------------------------------------------------------
// clbp_div
// Restoring divider, one quotient bit per cycle, 16 steps.
// ----------------------------------------------------------------------------
module clbp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [clbp_pkg::DivW-1:0]   rem_init_i,
  input  logic [clbp_pkg::DivW-1:0]   num_i,
  input  logic [clbp_pkg::DivW-1:0]   den_i,
  output logic                        done_o,
  output logic [clbp_pkg::DivW-1:0]   quo_o
);

  localparam int unsigned W  = clbp_pkg::DivW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, num_q, den_q, quo_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [W:0]    r2;
  logic          ge;

  assign r2 = {rem_q, num_q[W-1]};
  assign ge = (r2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      num_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? W'(r2 - {1'b0, den_q}) : r2[W-1:0];
      num_q <= {num_q[W-2:0], 1'b0};
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/clbp_dp.sv
// ----------------------------------------------------------------------------
// clbp_dp
// Datapath: config registers, line stores, window, LBP code, cell tracking,
// histogram memory and output register.
// ----------------------------------------------------------------------------
module clbp_dp #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_GRID   = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_addr_i,
  input  logic [8:0]                      cfg_wdata_i,
  input  logic [clbp_pkg::InDataW-1:0]    s_tdata_i,
  input  logic                            s_tuser_i,
  output logic [clbp_pkg::OutDataW-1:0]   m_tdata_o,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  input  clbp_pkg::cmd_t                  cmd_i,
  output clbp_pkg::status_t               status_o
);

  localparam int unsigned EW        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EH        = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CLW       = $clog2(MAX_WIDTH);
  localparam int unsigned GW        = $clog2(MAX_GRID + 1);
  localparam int unsigned NumCells  = MAX_GRID * MAX_GRID;
  localparam int unsigned CellW     = $clog2(NumCells);
  localparam int unsigned HAW       = CellW + 8;
  localparam int unsigned HistDepth = NumCells * 256;
  localparam int unsigned DW        = clbp_pkg::DivW;

  // config
  logic [8:0] img_w_q, img_h_q;
  logic [3:0] gcols_q, grows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 9'd256;
      img_h_q <= 9'd256;
      gcols_q <= 4'd8;
      grows_q <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        clbp_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg_wdata_i;
        clbp_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg_wdata_i;
        clbp_pkg::REG_GRID_COLS:    gcols_q <= cfg_wdata_i[3:0];
        clbp_pkg::REG_GRID_ROWS:    grows_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] eff_w;
  logic [EH-1:0] eff_h;
  logic [GW-1:0] eff_gc, eff_gr;

  always_comb begin
    if (img_w_q < 9'd3)                  eff_w = EW'(3);
    else if (32'(img_w_q) > MAX_WIDTH)   eff_w = EW'(MAX_WIDTH);
    else                                 eff_w = EW'(img_w_q);
    if (img_h_q < 9'd3)                  eff_h = EH'(3);
    else if (32'(img_h_q) > MAX_HEIGHT)  eff_h = EH'(MAX_HEIGHT);
    else                                 eff_h = EH'(img_h_q);
    if (gcols_q < 4'd1)                  eff_gc = GW'(1);
    else if (32'(gcols_q) > MAX_GRID)    eff_gc = GW'(MAX_GRID);
    else                                 eff_gc = GW'(gcols_q);
    if (grows_q < 4'd1)                  eff_gr = GW'(1);
    else if (32'(grows_q) > MAX_GRID)    eff_gr = GW'(MAX_GRID);
    else                                 eff_gr = GW'(grows_q);
  end

  // input word fields
  logic [7:0] pix_q, bin_q;
  logic [5:0] cidx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      pix_q  <= s_tdata_i[7:0];
      cidx_q <= s_tdata_i[14:9];
      bin_q  <= s_tdata_i[22:15];
    end
  end

  // shared divider
  logic [DW-1:0] div_rem, div_num, div_den, div_quo;
  logic          div_done;
  logic [DW-1:0] cnt_q;
  logic [15:0]   area_q;

  always_comb begin
    div_rem = '0;
    div_num = DW'(eff_w - EW'(2));
    div_den = DW'(eff_gc);
    case (cmd_i.div_sel)
      clbp_pkg::DIV_CELL_H: begin
        div_num = DW'(eff_h - EH'(2));
        div_den = DW'(eff_gr);
      end
      clbp_pkg::DIV_FRAC: begin
        div_rem = cnt_q;
        div_num = '0;
        div_den = area_q;
      end
      default: ;
    endcase
  end

  clbp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .rem_init_i (div_rem),
    .num_i      (div_num),
    .den_i      (div_den),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // frame geometry and positions
  logic [EW-1:0]  cw_q, xo_q, gx_q;
  logic [EH-1:0]  ch_q, yo_q, gy_q, row_q;
  logic [CLW-1:0] col_q;
  logic           wrap;

  assign wrap = (32'(col_q) + 1 >= 32'(eff_w));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q   <= '0;
      ch_q   <= '0;
      area_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
      xo_q   <= '0;
      gx_q   <= '0;
      yo_q   <= '0;
      gy_q   <= '0;
    end else begin
      if (cmd_i.ld_cw) cw_q <= EW'(div_quo);
      if (cmd_i.ld_ch) ch_q <= EH'(div_quo);
      if (cmd_i.init_frame) begin
        area_q <= 16'(32'(cw_q) * 32'(ch_q));
        col_q  <= '0;
        row_q  <= '0;
        xo_q   <= '0;
        gx_q   <= '0;
        yo_q   <= '0;
        gy_q   <= '0;
      end else if (cmd_i.pix_exec) begin
        if (wrap) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
          xo_q  <= '0;
          gx_q  <= '0;
          if (row_q >= EH'(2)) begin
            if (yo_q + 1'b1 == ch_q) begin
              yo_q <= '0;
              gy_q <= gy_q + 1'b1;
            end else begin
              yo_q <= yo_q + 1'b1;
            end
          end
        end else begin
          col_q <= col_q + 1'b1;
          if (col_q >= CLW'(2)) begin
            if (xo_q + 1'b1 == cw_q) begin
              xo_q <= '0;
              gx_q <= gx_q + 1'b1;
            end else begin
              xo_q <= xo_q + 1'b1;
            end
          end
        end
      end
    end
  end

  // line stores
  logic [7:0] ls_top [MAX_WIDTH];
  logic [7:0] ls_mid [MAX_WIDTH];
  logic [7:0] top_q, mid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_rd) begin
      top_q <= ls_top[col_q];
      mid_q <= ls_mid[col_q];
    end
    if (cmd_i.pix_exec) begin
      ls_top[col_q] <= mid_q;
      ls_mid[col_q] <= pix_q;
    end
  end

  // 3x2 window, column 0 is the older one
  logic [7:0] win_q [3][2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
    end else if (cmd_i.pix_exec) begin
      for (int r = 0; r < 3; r++) win_q[r][0] <= win_q[r][1];
      win_q[0][1] <= top_q;
      win_q[1][1] <= mid_q;
      win_q[2][1] <= pix_q;
    end
  end

  function automatic logic diag_bit(input logic [7:0] corner, input logic [7:0] a,
                                    input logic [7:0] b, input logic [7:0] c);
    logic [25:0] s;
    s = 26'(corner) * 26'(clbp_pkg::W_CORNER)
      + (26'(a) + 26'(b)) * 26'(clbp_pkg::W_SIDE)
      + 26'(c) * 26'(clbp_pkg::W_CENTRE);
    return s >= (26'(c) << clbp_pkg::WeightBits);
  endfunction

  logic [7:0] code;
  logic [7:0] cc;

  assign cc = win_q[1][1];

  always_comb begin
    code[0] = mid_q >= cc;
    code[1] = diag_bit(top_q, win_q[0][1], mid_q, cc);
    code[2] = win_q[0][1] >= cc;
    code[3] = diag_bit(win_q[0][0], win_q[0][1], win_q[1][0], cc);
    code[4] = win_q[1][0] >= cc;
    code[5] = diag_bit(win_q[2][0], win_q[1][0], win_q[2][1], cc);
    code[6] = win_q[2][1] >= cc;
    code[7] = diag_bit(pix_q, win_q[2][1], mid_q, cc);
  end

  // cell of the current code
  logic [2*GW-1:0]  cell_full;
  logic [CellW-1:0] cell_sel;
  logic             count_ok;

  assign cell_full = (2*GW)'(GW'(gy_q)) * (2*GW)'(eff_gc) + (2*GW)'(GW'(gx_q));
  assign cell_sel  = CellW'(cell_full);
  assign count_ok  = (row_q >= EH'(2)) && (col_q >= CLW'(2)) && (cw_q != '0) &&
                     (ch_q != '0) && (32'(gx_q) < 32'(eff_gc)) &&
                     (32'(gy_q) < 32'(eff_gr));

  // histogram memory
  logic [15:0]  hist_mem [HistDepth];
  logic [15:0]  h_rd_q, h_wd;
  logic [HAW-1:0] h_ra, h_wa, hist_addr_q, clr_addr_q;
  logic         h_we;
  logic         cell_ok;

  assign cell_ok = (32'(cidx_q) < NumCells);
  assign h_ra    = cmd_i.rd_issue ? {CellW'(cidx_q), bin_q} : {cell_sel, code};
  assign h_we    = cmd_i.clr_en | cmd_i.hist_wr;
  assign h_wa    = cmd_i.clr_en ? clr_addr_q : hist_addr_q;
  assign h_wd    = cmd_i.clr_en ? 16'd0 : ((h_rd_q == 16'hFFFF) ? h_rd_q : h_rd_q + 16'd1);

  always_ff @(posedge clk_i) begin
    if (h_we) hist_mem[h_wa] <= h_wd;
    h_rd_q <= hist_mem[h_ra];
    if (cmd_i.pix_exec) hist_addr_q <= {cell_sel, code};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // read result
  logic [16:0] frac_q;
  logic [15:0] out_cnt_q;
  logic [16:0] out_frac_q;
  logic        out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_latch) begin
      cnt_q <= cell_ok ? h_rd_q : 16'd0;
      if (!cell_ok || area_q == '0)  frac_q <= '0;
      else if (h_rd_q >= area_q)     frac_q <= 17'h10000;
      else                           frac_q <= '0;
    end else if (cmd_i.frac_ld) begin
      frac_q <= {1'b0, div_quo};
    end
    if (cmd_i.out_load) begin
      out_cnt_q  <= cnt_q;
      out_frac_q <= frac_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {7'd0, out_frac_q, out_cnt_q};

  always_comb begin
    status_o          = '0;
    status_o.in_func  = s_tuser_i;
    status_o.in_sof   = s_tdata_i[8];
    status_o.div_done = div_done;
    status_o.clr_last = &clr_addr_q;
    status_o.pix_ok   = (row_q < eff_h);
    status_o.count_ok = count_ok;
    status_o.need_div = (area_q != '0) && (cnt_q < area_q) && (cnt_q != '0);
    status_o.out_free = !out_valid_q || m_tready_i;
  end

endmodule

### rtl/clbp_ctrl.sv
// ----------------------------------------------------------------------------
// clbp_ctrl
// Sequencer: steps one input word through frame setup, pixel update,
// histogram increment or bin read.
// ----------------------------------------------------------------------------
module clbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  clbp_pkg::status_t status_i,
  output clbp_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVW  = 4'd1;
  localparam logic [3:0] S_WAITW = 4'd2;
  localparam logic [3:0] S_DIVH  = 4'd3;
  localparam logic [3:0] S_WAITH = 4'd4;
  localparam logic [3:0] S_AREA  = 4'd5;
  localparam logic [3:0] S_CLR   = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_EXEC  = 4'd8;
  localparam logic [3:0] S_HWR   = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;
  localparam logic [3:0] S_RDAT  = 4'd11;
  localparam logic [3:0] S_RCHK  = 4'd12;
  localparam logic [3:0] S_RDIV  = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;
  localparam logic [3:0] S_INIT  = 4'd15;

  logic [3:0] state_q, state_d;

  // histogram memory is cleared once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_INIT;
    else         state_q <= state_d;
  end

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.take_in = 1'b1;
          if (status_i.in_func == clbp_pkg::FUNC_READ) state_d = S_RD;
          else if (status_i.in_sof)                    state_d = S_DIVW;
          else                                         state_d = S_CHK;
        end
      end
      S_DIVW: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = clbp_pkg::DIV_CELL_W;
        state_d         = S_WAITW;
      end
      S_WAITW: begin
        if (status_i.div_done) begin
          cmd_o.ld_cw = 1'b1;
          state_d     = S_DIVH;
        end
      end
      S_DIVH: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = clbp_pkg::DIV_CELL_H;
        state_d         = S_WAITH;
      end
      S_WAITH: begin
        if (status_i.div_done) begin
          cmd_o.ld_ch = 1'b1;
          state_d     = S_AREA;
        end
      end
      S_AREA: begin
        cmd_o.init_frame = 1'b1;
        state_d          = S_CLR;
      end
      S_CLR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) state_d = S_CHK;
      end
      S_CHK: begin
        if (status_i.pix_ok) begin
          cmd_o.pix_rd = 1'b1;
          state_d      = S_EXEC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EXEC: begin
        cmd_o.pix_exec = 1'b1;
        state_d        = status_i.count_ok ? S_HWR : S_IDLE;
      end
      S_HWR: begin
        cmd_o.hist_wr = 1'b1;
        state_d       = S_IDLE;
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_RDAT;
      end
      S_RDAT: begin
        cmd_o.rd_latch = 1'b1;
        state_d        = S_RCHK;
      end
      S_RCHK: begin
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = clbp_pkg::DIV_FRAC;
          state_d         = S_RDIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RDIV: begin
        cmd_o.div_sel = clbp_pkg::DIV_FRAC;
        if (status_i.div_done) begin
          cmd_o.frac_ld = 1'b1;
          state_d       = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
